// ===== rtl/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared widths, types and reset values for the perspective point transform.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int CoordW = 32;               // Q16.16 coordinate
  localparam int RegW   = 64;               // one register, two coefficients
  localparam int RegN   = 8;
  localparam int IdxW   = $clog2(RegN);
  localparam int SumW   = 67;               // exact Q.32 dot product
  localparam int NumW   = SumW + 16;        // |sum| << 16
  localparam int RemW   = SumW + 32;        // remainder, below divisor << 32
  localparam int QuoW   = 32;               // quotient bits kept
  localparam int DivN   = QuoW;             // one quotient bit per stage

  localparam logic [RegW-1:0] RegReset [RegN] = '{
    64'h0001_0000_0000_0000, 64'h0,
    64'h0000_0000_0001_0000, 64'h0,
    64'h0,                   64'h0001_0000_0000_0000,
    64'h0,                   64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic                     valid;
    logic                     wzero;
    logic [SumW-1:0]          dvs;     // |w|, or one when w is zero
    logic [2:0]               neg;     // result sign per coordinate
    logic [2:0]               ovf;     // quotient known to exceed 32 bits
    logic [2:0][CoordW-1:0]   zres;    // saturated result for zero w
    logic [2:0]               zclip;
    div_lane_t [2:0]          lane;
  } div_pipe_t;

endpackage

// ===== rtl/ptp_div_stage.sv =====
// ----------------------------------------------------------------------------
// ptp_div_stage
// One restoring-division step for three coordinates sharing one divisor.
// ----------------------------------------------------------------------------
module ptp_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ptp_pkg::div_pipe_t pipe_i,
  output ptp_pkg::div_pipe_t pipe_o
);
  import ptp_pkg::*;

  div_pipe_t       pipe_nxt;
  div_pipe_t       pipe_r;
  logic [RemW-1:0] dsh;
  logic [RemW-1:0] diff [3];
  logic [2:0]      qbit;

  // divisor aligned to quotient bit 31; remainder doubles every step
  assign dsh = {1'b0, pipe_i.dvs, 31'b0};

  always_comb begin
    pipe_nxt = pipe_i;
    for (int k = 0; k < 3; k++) begin
      qbit[k] = (pipe_i.lane[k].rem >= dsh);
      diff[k] = pipe_i.lane[k].rem - dsh;
      pipe_nxt.lane[k].rem = (qbit[k] ? diff[k] : pipe_i.lane[k].rem) << 1;
      pipe_nxt.lane[k].quo = {pipe_i.lane[k].quo[QuoW-2:0], qbit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign pipe_o = pipe_r;

endmodule

// ===== rtl/point_transform_perspective.sv =====
// ----------------------------------------------------------------------------
// point_transform_perspective
// 4x4 homogeneous point transform with perspective divide, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one point per item (valid/ready). out_* : one result per item.
//   cfg_*  : write-only matrix port, cfg_we with cfg_index 0..7 selects
//            row<r>_left / row<r>_right; write only while the block is idle.
//   Stages from input accept to out_valid: one multiply stage,
//   two add stages, one sign/overflow stage, 32 division stages (one
//   quotient bit each, three coordinates sharing the w divisor) and one
//   saturation stage feeding the output register.
//   Throughput: one item per cycle while the output is not stalled; every stage is a register.
//   Stall: the whole pipeline holds while out_valid is high and out_ready
//   low; in_ready drops in the same cycle, so nothing is lost or repeated.
//   Reset: clears all stage valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module point_transform_perspective (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ptp_pkg::IdxW-1:0]      cfg_index,
  input  logic [ptp_pkg::RegW-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ptp_pkg::CoordW-1:0] in_point_x,
  input  logic signed [ptp_pkg::CoordW-1:0] in_point_y,
  input  logic signed [ptp_pkg::CoordW-1:0] in_point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ptp_pkg::CoordW-1:0] out_x,
  output logic signed [ptp_pkg::CoordW-1:0] out_y,
  output logic signed [ptp_pkg::CoordW-1:0] out_z,
  output logic                          out_w_was_zero,
  output logic                          out_clipped
);
  import ptp_pkg::*;

  logic [RegW-1:0] cfg_r [RegN];

  logic                      en;
  logic signed [CoordW-1:0]  pt [3];
  logic signed [CoordW-1:0]  coef [4][4];

  logic                      v1_r, v2_r, v3_r;
  logic signed [63:0]        prod_r [4][3];
  logic signed [47:0]        trn_r [4];
  logic signed [SumW-1:0]    a_r [4];
  logic signed [SumW-1:0]    b_r [4];
  logic signed [SumW-1:0]    s_r [4];

  div_pipe_t                 prep_nxt;
  div_pipe_t                 pipe [DivN+1];
  logic [SumW-1:0]           wmag;
  logic [SumW-1:0]           mag [3];
  logic [NumW-1:0]           num [3];
  logic signed [50:0]        zv [3];
  logic [2:0]                zfit;

  logic [CoordW-1:0]         res_nxt [3];
  logic [2:0]                clip_nxt;
  logic                      out_valid_r;
  logic [CoordW-1:0]         out_r [3];
  logic                      wz_r;
  logic                      clip_r;

  // whole pipeline advances unless the output item is stalled
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RegN; i++) cfg_r[i] <= RegReset[i];
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      coef[r][0] = cfg_r[2*r][63:32];
      coef[r][1] = cfg_r[2*r][31:0];
      coef[r][2] = cfg_r[2*r+1][63:32];
      coef[r][3] = cfg_r[2*r+1][31:0];
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) prod_r[r][c] <= coef[r][c] * pt[c];
        trn_r[r] <= {coef[r][3], 16'b0};
      end
    end
  end

  // stage 2 and 3: exact sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        a_r[r] <= SumW'(prod_r[r][0]) + SumW'(prod_r[r][1]);
        b_r[r] <= SumW'(prod_r[r][2]) + SumW'(trn_r[r]);
        s_r[r] <= a_r[r] + b_r[r];
      end
    end
  end

  // stage 4: magnitudes, overflow check, zero-w result
  assign wmag = s_r[3][SumW-1] ? SumW'(-s_r[3]) : s_r[3];

  always_comb begin
    prep_nxt.valid = v3_r;
    prep_nxt.wzero = (s_r[3] == '0);
    prep_nxt.dvs   = prep_nxt.wzero ? SumW'(1) : wmag;
    for (int k = 0; k < 3; k++) begin
      mag[k] = s_r[k][SumW-1] ? SumW'(-s_r[k]) : s_r[k];
      num[k] = {mag[k], 16'b0};
      prep_nxt.neg[k] = s_r[k][SumW-1] ^ s_r[3][SumW-1];
      prep_nxt.ovf[k] = ({16'b0, num[k]} >= {wmag, 32'b0});
      prep_nxt.lane[k].rem = {16'b0, num[k]};
      prep_nxt.lane[k].quo = '0;
      // floor shift, then saturate
      zv[k]   = s_r[k][SumW-1:16];
      zfit[k] = (&zv[k][50:31]) || !(|zv[k][50:31]);
      prep_nxt.zres[k]  = zfit[k] ? zv[k][31:0]
                        : (zv[k][50] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      prep_nxt.zclip[k] = !zfit[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0] <= prep_nxt;
    end
  end

  for (genvar g = 0; g < DivN; g++) begin : g_div
    ptp_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .pipe_i (pipe[g]),
      .pipe_o (pipe[g+1])
    );
  end

  // final stage: sign and saturate, or the zero-w result
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pipe[DivN].wzero) begin
        res_nxt[k]  = pipe[DivN].zres[k];
        clip_nxt[k] = pipe[DivN].zclip[k];
      end else if (pipe[DivN].neg[k]) begin
        clip_nxt[k] = pipe[DivN].ovf[k] || (pipe[DivN].lane[k].quo > 32'h8000_0000);
        res_nxt[k]  = clip_nxt[k] ? 32'h8000_0000 : (32'h0 - pipe[DivN].lane[k].quo);
      end else begin
        clip_nxt[k] = pipe[DivN].ovf[k] || pipe[DivN].lane[k].quo[QuoW-1];
        res_nxt[k]  = clip_nxt[k] ? 32'h7FFF_FFFF : pipe[DivN].lane[k].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pipe[DivN].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) out_r[k] <= res_nxt[k];
      wz_r   <= pipe[DivN].wzero;
      clip_r <= |clip_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_r[0];
  assign out_y          = out_r[1];
  assign out_z          = out_r[2];
  assign out_w_was_zero = wz_r;
  assign out_clipped    = clip_r;

  a_ready_follows_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_clip_means_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_x == 32'sh7FFF_FFFF || out_x == -32'sh8000_0000 ||
       out_y == 32'sh7FFF_FFFF || out_y == -32'sh8000_0000 ||
       out_z == 32'sh7FFF_FFFF || out_z == -32'sh8000_0000))
    else $error("clipped set without a saturated coordinate");

  a_stall_keeps_item : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_clipped)))
    else $error("stalled item dropped or changed");

endmodule
